// ----- rtl/stack_machine_alu_core_macros.svh -----
// Assertion macros shared by the stack machine RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef STACK_MACHINE_ALU_CORE_MACROS_SVH
`define STACK_MACHINE_ALU_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SMAC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smac assertion failed");
`define SMAC_ASSERT_NR(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("smac reset assertion failed");
`else
`define SMAC_ASSERT(label, prop)
`define SMAC_ASSERT_NR(label, prop)
`endif
`endif

// ----- rtl/smac_pkg.sv -----
// Types and constants for the stack machine ALU core.
// No dependencies; used by smac_cell, smac_alu and stack_machine_alu_core.
`timescale 1ns / 1ps
`default_nettype none

package smac_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int IMM_W   = 32;
  localparam int MODE_W  = 4;
  localparam int DEPTH_W = 11;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [MODE_W-1:0] {
    OP_CONST = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_SWAP  = 4'd3,
    OP_MUL   = 4'd4,
    OP_MAX   = 4'd5,
    OP_MIN   = 4'd6,
    OP_DIV   = 4'd7,
    OP_DUP   = 4'd8,
    OP_NEG   = 4'd9,
    OP_END   = 4'd10
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op_top;
    cell_op_t op_second;
    cell_op_t op_rest;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;

  typedef struct packed {
    logic busy;
  } alu_rsp_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [IMM_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    status_t                  status;
    logic                     halted;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/smac_cell.sv -----
// One stack cell: holds a word, takes its upper neighbor on push, lower on pop.
// Depends on smac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smac_cell
  import smac_pkg::*;
(
  input  wire logic     clk,
  input  wire cell_op_t op,
  input  wire word_t    above,
  input  wire word_t    below,
  output word_t         q
);

  word_t q_r;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_PUSH: q_r <= above;
      CELL_POP:  q_r <= below;
      default:   q_r <= q_r;
    endcase
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- rtl/smac_alu.sv -----
// Multi-cycle arithmetic unit: 64-bit wrapping multiply from 32x32 partial
// products, and signed restoring divide one quotient bit per cycle. Uses smac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smac_alu
  import smac_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  input  wire word_t    opa,
  input  wire word_t    opb,
  output alu_rsp_t      rsp,
  output word_t         result
);

  localparam int STEP_W = $clog2(WORD_W);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(3);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(WORD_W - 1);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} astate_t;

  astate_t             state_r;
  logic [STEP_W-1:0]   step_r;
  word_t               mula_r, mulb_r, acc_r, rem_r, dvsr_r;
  logic [WORD_W-1:0]   prod_r;
  logic                neg_r;

  logic [HALF_W-1:0]   mul_x, mul_y;
  logic [WORD_W-1:0]   prod_w;
  word_t               rem_sh, rem_sub, opa_abs, opb_abs;
  logic                take;

  assign mul_x   = (step_r == STEP_W'(2)) ? mula_r[WORD_W-1:HALF_W] : mula_r[HALF_W-1:0];
  assign mul_y   = (step_r == STEP_W'(1)) ? mulb_r[WORD_W-1:HALF_W] : mulb_r[HALF_W-1:0];
  assign prod_w  = WORD_W'(mul_x) * WORD_W'(mul_y);

  assign rem_sh  = {rem_r[WORD_W-2:0], acc_r[WORD_W-1]};
  assign take    = (rem_sh >= dvsr_r);
  assign rem_sub = rem_sh - dvsr_r;
  assign opa_abs = opa[WORD_W-1] ? (~opa + WORD_W'(1)) : opa;
  assign opb_abs = opb[WORD_W-1] ? (~opb + WORD_W'(1)) : opb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        A_IDLE: begin
          step_r <= '0;
          if (req.start) begin
            state_r <= req.div ? A_DIV : A_MUL;
          end
        end
        A_MUL: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == MUL_LAST) begin
            state_r <= A_IDLE;
          end
        end
        A_DIV: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == DIV_LAST) begin
            state_r <= A_FIX;
          end
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      A_IDLE: begin
        if (req.start && req.div) begin
          acc_r  <= opa_abs;
          rem_r  <= '0;
          dvsr_r <= opb_abs;
          neg_r  <= opa[WORD_W-1] ^ opb[WORD_W-1];
        end else if (req.start) begin
          mula_r <= opa;
          mulb_r <= opb;
        end
      end
      A_MUL: begin
        if (step_r != MUL_LAST) begin
          prod_r <= prod_w;
        end
        if (step_r == STEP_W'(1)) begin
          acc_r <= prod_r;
        end else if (step_r != STEP_W'(0)) begin
          acc_r <= acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
        end
      end
      A_DIV: begin
        rem_r <= take ? rem_sub : rem_sh;
        acc_r <= {acc_r[WORD_W-2:0], take};
      end
      default: begin
        if (neg_r) begin
          acc_r <= ~acc_r + WORD_W'(1);
        end
      end
    endcase
  end

  assign rsp.busy = (state_r != A_IDLE);
  assign result   = acc_r;

endmodule

`default_nettype wire

// ----- rtl/stack_machine_alu_core.sv -----
// Stack machine ALU core: a row of stack cells, a sequencer and a shared
// multi-cycle multiply/divide unit. Uses smac_pkg, smac_cell, smac_alu.
//
// Usage:
//   in_valid/in_ready/in_data carry one instruction (mode, 32-bit value) per
//   transaction; out_valid/out_ready/out_data return one result per
//   instruction (top of stack, depth, status, halted), in order.
//   The stack is a chain of STACK_DEPTH cells; the top sits in cell 0 and all
//   cells shift together on push and pop, so every instruction reaches its
//   operands at fixed cells.
//   Const, add, sub, swap, max, min, dup, neg and end, and any flagged
//   instruction, finish in the sequencer alone; mul waits on the shared unit
//   (three 32x32 partial products on one multiplier) and div waits on it
//   too (one quotient bit per cycle, plus sign fix).
//   One instruction is in flight at a time; the next is taken once the
//   previous one has been written to the output register.
//   A stalled receiver holds the result in the output register; an instruction
//   already taken finishes its work and waits there until the register frees.
//   Reset empties the stack (depth 0); cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_alu_core_macros.svh"

module stack_machine_alu_core
  import smac_pkg::*;
#(
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ALU} state_t;

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  word_t             imm_r;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;

  word_t             cell_q [STACK_DEPTH];
  word_t             a, b, bin_res, load_dec, top_dec, alu_result;
  cell_ctl_t         ctl_dec, cell_ctl;
  status_t           st_dec;
  logic              halt_dec, needs_alu, out_free, commit;
  logic [DW-1:0]     depth_dec;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign a = cell_q[0];
  assign b = cell_q[1];

  always_comb begin
    unique case (mode_r)
      OP_ADD:  bin_res = a + b;
      OP_SUB:  bin_res = a - b;
      OP_MAX:  bin_res = ($signed(a) > $signed(b)) ? a : b;
      OP_MIN:  bin_res = ($signed(a) > $signed(b)) ? b : a;
      default: bin_res = alu_result;
    endcase
  end

  always_comb begin
    ctl_dec   = '{op_top: CELL_HOLD, op_second: CELL_HOLD, op_rest: CELL_HOLD};
    load_dec  = a;
    st_dec    = ST_OK;
    halt_dec  = 1'b0;
    depth_dec = depth_r;
    needs_alu = 1'b0;
    unique case (mode_r)
      OP_CONST: begin
        if (depth_r == FULL) begin
          st_dec = ST_OVERFLOW;
        end else begin
          ctl_dec   = '{op_top: CELL_PUSH, op_second: CELL_PUSH, op_rest: CELL_PUSH};
          load_dec  = imm_r;
          depth_dec = depth_r + DW'(1);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_MAX, OP_MIN, OP_DIV: begin
        if (depth_r < DW'(2)) begin
          st_dec = ST_UNDERFLOW;
        end else if (mode_r == OP_DIV && b == '0) begin
          st_dec = ST_DIV_ZERO;
        end else begin
          ctl_dec   = '{op_top: CELL_PUSH, op_second: CELL_POP, op_rest: CELL_POP};
          load_dec  = bin_res;
          depth_dec = depth_r - DW'(1);
          needs_alu = (mode_r == OP_MUL) || (mode_r == OP_DIV);
        end
      end
      OP_SWAP: begin
        if (depth_r < DW'(2)) begin
          st_dec = ST_UNDERFLOW;
        end else begin
          ctl_dec  = '{op_top: CELL_PUSH, op_second: CELL_PUSH, op_rest: CELL_HOLD};
          load_dec = b;
        end
      end
      OP_DUP: begin
        if (depth_r == '0) begin
          st_dec = ST_UNDERFLOW;
        end else if (depth_r == FULL) begin
          st_dec = ST_OVERFLOW;
        end else begin
          ctl_dec   = '{op_top: CELL_PUSH, op_second: CELL_PUSH, op_rest: CELL_PUSH};
          load_dec  = a;
          depth_dec = depth_r + DW'(1);
        end
      end
      OP_NEG: begin
        if (depth_r == '0) begin
          st_dec = ST_UNDERFLOW;
        end else begin
          ctl_dec.op_top = CELL_PUSH;
          load_dec       = ~a + WORD_W'(1);
        end
      end
      OP_END: begin
        halt_dec = 1'b1;
        if (depth_r == '0) begin
          st_dec = ST_UNDERFLOW;
        end
      end
      default: begin
      end
    endcase
  end

  assign top_dec = (ctl_dec.op_top == CELL_HOLD) ? a : load_dec;

  // sequencer
  always_comb begin
    out_free      = !out_valid_r || out_ready;
    commit        = 1'b0;
    alu_req.start = 1'b0;
    alu_req.div   = (mode_r == OP_DIV);
    state_nxt     = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (needs_alu) begin
          alu_req.start = 1'b1;
          state_nxt     = S_ALU;
        end else if (out_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        if (!alu_rsp.busy && out_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  assign cell_ctl  = commit ? ctl_dec
                            : '{op_top: CELL_HOLD, op_second: CELL_HOLD, op_rest: CELL_HOLD};
  assign depth_nxt = commit ? depth_dec : depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_data.mode;
      imm_r  <= {{(WORD_W - IMM_W){in_data.value[IMM_W-1]}}, in_data.value};
    end
    if (commit) begin
      out_data_r.top_value <= (depth_dec != '0) ? top_dec : '0;
      out_data_r.depth     <= DEPTH_W'(depth_dec);
      out_data_r.status    <= st_dec;
      out_data_r.halted    <= halt_dec;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t    above_w, below_w;
    cell_op_t op_w;

    if (i == 0) begin : g_top
      assign above_w = load_dec;
      assign op_w    = cell_ctl.op_top;
    end else if (i == 1) begin : g_second
      assign above_w = cell_q[i-1];
      assign op_w    = cell_ctl.op_second;
    end else begin : g_rest
      assign above_w = cell_q[i-1];
      assign op_w    = cell_ctl.op_rest;
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below_w = '0;
    end else begin : g_inner
      assign below_w = cell_q[i+1];
    end

    smac_cell u_cell (
      .clk   (clk),
      .op    (op_w),
      .above (above_w),
      .below (below_w),
      .q     (cell_q[i])
    );
  end

  smac_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (a),
    .opb    (b),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SMAC_ASSERT(a_depth_only_on_commit, !commit |=> depth_r == $past(depth_r))
  `SMAC_ASSERT(a_alu_start_operands, alu_req.start |-> depth_r >= DW'(2) && !alu_rsp.busy)
  `SMAC_ASSERT(a_overflow_when_full, commit && st_dec == ST_OVERFLOW |-> depth_r == FULL)
  `SMAC_ASSERT(a_depth_bounded, depth_r <= FULL)
  `SMAC_ASSERT_NR(a_reset_clears, !rst_n |=> !out_valid_r && state_r == S_IDLE)

endmodule

`default_nettype wire
